// ===== hdl/cscd_pkg.sv =====
// ----------------------------------------------------------------------------
// cscd_pkg
// Shared types and constants of the CAN signal decoder with change detection.
// ----------------------------------------------------------------------------
`default_nettype none

package cscd_pkg;

    // Frame identifiers; only an exact match of the whole word decodes
    localparam logic [31:0] ID_SWITCH  = 32'h0000_0300;
    localparam logic [31:0] ID_GEAR    = 32'h0000_0301;
    localparam logic [31:0] ID_SPEED   = 32'h0000_0400;
    localparam logic [31:0] ID_WARNING = 32'h0000_0401;
    localparam logic [31:0] ID_VEHICLE = 32'h0000_0500;
    localparam logic [31:0] ID_ENGINE  = 32'h0000_0501;

    // Minimum length codes per frame
    localparam logic [3:0] DLC_SWITCH  = 4'd2;
    localparam logic [3:0] DLC_GEAR    = 4'd1;
    localparam logic [3:0] DLC_SPEED   = 4'd4;
    localparam logic [3:0] DLC_WARNING = 4'd2;
    localparam logic [3:0] DLC_VEHICLE = 4'd6;
    localparam logic [3:0] DLC_ENGINE  = 4'd3;

    // Event kinds
    localparam logic [3:0] KIND_SWITCH  = 4'd0;
    localparam logic [3:0] KIND_GEAR    = 4'd1;
    localparam logic [3:0] KIND_SPEED   = 4'd2;
    localparam logic [3:0] KIND_RPM     = 4'd3;
    localparam logic [3:0] KIND_WARNING = 4'd4;
    localparam logic [3:0] KIND_ABS     = 4'd5;
    localparam logic [3:0] KIND_TCS     = 4'd6;
    localparam logic [3:0] KIND_TEMP    = 4'd7;
    localparam logic [3:0] KIND_OIL     = 4'd8;
    localparam logic [3:0] KIND_FUEL    = 4'd9;

    // Divide by ten: x * 52429 >> 19 is exact for every 16-bit x
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int SPEED_W  = 13;
    localparam int MAX_EVTS = 3;

    typedef struct packed {
        logic [31:0]      can_id;
        logic [3:0]       dlc;
        logic [5:0][7:0]  data;
        logic [SPEED_W-1:0] speed;   // (byte0 << 8 | byte1) / 10
    } t_frame;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
    } t_event;

    typedef struct packed {
        logic [1:0]             cnt;
        t_event [MAX_EVTS-1:0]  evts;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hdl/cscd_in_stage.sv =====
// ----------------------------------------------------------------------------
// cscd_in_stage
// Input register: captures one frame and its speed quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cscd_in_stage
    import cscd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_can_id,
    input  wire logic [3:0]  i_dlc,
    input  wire logic [5:0][7:0] i_data,
    input  wire logic        i_take,
    output logic             o_frame_vld,
    output t_frame           o_frame
);

    logic        r_vld;
    t_frame      r_frame;
    logic [31:0] w_prod;

    // Reciprocal multiply in place of a divider
    assign w_prod  = {i_data[0], i_data[1]} * DIV10_RECIP;
    assign o_ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame.can_id <= i_can_id;
            r_frame.dlc    <= i_dlc;
            r_frame.data   <= i_data;
            r_frame.speed  <= w_prod[DIV10_SHIFT +: SPEED_W];
        end
    end

    assign o_frame_vld = r_vld;
    assign o_frame     = r_frame;

endmodule

`default_nettype wire

// ===== hdl/cscd_decode.sv =====
// ----------------------------------------------------------------------------
// cscd_decode
// Signal store, change compare and event compaction for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cscd_decode
    import cscd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_frame  i_frame,
    input  wire logic    i_fire,
    output t_bundle      o_bundle
);

    logic [15:0]        r_switch, n_switch;
    logic [7:0]         r_gear, n_gear;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [15:0]        r_rpm, n_rpm;
    logic [15:0]        r_warn, n_warn;
    logic               r_abs, n_abs;
    logic               r_tcs, n_tcs;
    logic [7:0]         r_temp, n_temp;
    logic [7:0]         r_oil, n_oil;
    logic [7:0]         r_fuel, n_fuel;

    t_event [MAX_EVTS-1:0] w_cand;
    logic   [MAX_EVTS-1:0] w_chg;
    logic   [5:0][7:0]     b;

    assign b = i_frame.data;

    // Decode the frame into new store values and up to three candidates
    always_comb begin
        n_switch = r_switch;
        n_gear   = r_gear;
        n_speed  = r_speed;
        n_rpm    = r_rpm;
        n_warn   = r_warn;
        n_abs    = r_abs;
        n_tcs    = r_tcs;
        n_temp   = r_temp;
        n_oil    = r_oil;
        n_fuel   = r_fuel;
        w_cand   = '0;
        w_chg    = '0;
        unique case (i_frame.can_id)
            ID_SWITCH: begin
                if (i_frame.dlc >= DLC_SWITCH) begin
                    n_switch  = {b[1], b[0]};
                    w_cand[0] = '{KIND_SWITCH, n_switch};
                    w_chg[0]  = n_switch != r_switch;
                end
            end
            ID_GEAR: begin
                if (i_frame.dlc >= DLC_GEAR) begin
                    n_gear    = b[0];
                    w_cand[0] = '{KIND_GEAR, {8'd0, n_gear}};
                    w_chg[0]  = n_gear != r_gear;
                end
            end
            ID_SPEED: begin
                if (i_frame.dlc >= DLC_SPEED) begin
                    n_speed   = i_frame.speed;
                    n_rpm     = {b[2], b[3]};
                    w_cand[0] = '{KIND_SPEED, {3'd0, n_speed}};
                    w_chg[0]  = n_speed != r_speed;
                    w_cand[1] = '{KIND_RPM, n_rpm};
                    w_chg[1]  = n_rpm != r_rpm;
                end
            end
            ID_WARNING: begin
                if (i_frame.dlc >= DLC_WARNING) begin
                    n_warn    = {b[1], b[0]};
                    w_cand[0] = '{KIND_WARNING, n_warn};
                    w_chg[0]  = n_warn != r_warn;
                end
            end
            ID_VEHICLE: begin
                if (i_frame.dlc >= DLC_VEHICLE) begin
                    n_gear    = b[4];
                    n_abs     = b[5][0];
                    n_tcs     = b[5][1];
                    w_cand[0] = '{KIND_GEAR, {8'd0, n_gear}};
                    w_chg[0]  = n_gear != r_gear;
                    w_cand[1] = '{KIND_ABS, {15'd0, n_abs}};
                    w_chg[1]  = n_abs != r_abs;
                    w_cand[2] = '{KIND_TCS, {15'd0, n_tcs}};
                    w_chg[2]  = n_tcs != r_tcs;
                end
            end
            ID_ENGINE: begin
                if (i_frame.dlc >= DLC_ENGINE) begin
                    n_temp    = b[0];
                    n_oil     = b[1];
                    n_fuel    = b[2];
                    w_cand[0] = '{KIND_TEMP, {8'd0, n_temp}};
                    w_chg[0]  = n_temp != r_temp;
                    w_cand[1] = '{KIND_OIL, {8'd0, n_oil}};
                    w_chg[1]  = n_oil != r_oil;
                    w_cand[2] = '{KIND_FUEL, {8'd0, n_fuel}};
                    w_chg[2]  = n_fuel != r_fuel;
                end
            end
            default: begin
            end
        endcase
    end

    // Pack the changed candidates to the front, keeping their order
    always_comb begin
        logic [1:0] n;
        n        = 2'd0;
        o_bundle = '0;
        for (int i = 0; i < MAX_EVTS; i++) begin
            if (w_chg[i]) begin
                o_bundle.evts[n] = w_cand[i];
                n = n + 2'd1;
            end
        end
        o_bundle.cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch <= '0;
            r_gear   <= '0;
            r_speed  <= '0;
            r_rpm    <= '0;
            r_warn   <= '0;
            r_abs    <= 1'b0;
            r_tcs    <= 1'b0;
            r_temp   <= '0;
            r_oil    <= '0;
            r_fuel   <= '0;
        end else if (i_fire) begin
            r_switch <= n_switch;
            r_gear   <= n_gear;
            r_speed  <= n_speed;
            r_rpm    <= n_rpm;
            r_warn   <= n_warn;
            r_abs    <= n_abs;
            r_tcs    <= n_tcs;
            r_temp   <= n_temp;
            r_oil    <= n_oil;
            r_fuel   <= n_fuel;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cscd_out_queue.sv =====
// ----------------------------------------------------------------------------
// cscd_out_queue
// Holds the events of one frame and hands them out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cscd_out_queue
    import cscd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_bundle i_bundle,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_event       o_event,
    output logic         o_last
);

    logic [1:0]            r_cnt;
    t_event [MAX_EVTS-1:0] r_evts;
    logic                  w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign w_pop   = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);
    assign o_event = r_evts[0];
    assign o_last  = r_cnt == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Advance the remaining events towards the head on each beat
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evts <= i_bundle.evts;
        end else if (w_pop) begin
            r_evts[0] <= r_evts[1];
            r_evts[1] <= r_evts[2];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/can_signal_decoder_change_detect_unit.sv =====
// ----------------------------------------------------------------------------
// can_signal_decoder_change_detect_unit
// Decodes dashboard CAN frames and emits one event per changed signal.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Beat
//  frame    in         i_valid / o_ready   id, length code, data bytes 0..5
//  event    out        o_valid / i_ready   kind, value, last-of-frame flag
//
//  A frame is captured in the input register with its speed word divided
//  by ten; the compare and store update then loads its events into the
//  output queue, which drains one per cycle while i_ready is high, one to
//  three events a frame, none when nothing changed. Reset clears the signal
//  store and empties both stages. A stall on the event side holds the queue,
//  and the input register then holds its frame until the queue frees.
//
`default_nettype none

module can_signal_decoder_change_detect_unit
    import cscd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_can_id,
    input  wire logic [3:0]  i_dlc,
    input  wire logic [7:0]  i_data_byte0,
    input  wire logic [7:0]  i_data_byte1,
    input  wire logic [7:0]  i_data_byte2,
    input  wire logic [7:0]  i_data_byte3,
    input  wire logic [7:0]  i_data_byte4,
    input  wire logic [7:0]  i_data_byte5,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_signal_kind,
    output logic [15:0]      o_signal_value,
    output logic             o_last_of_frame
);

    logic            w_frame_vld;
    t_frame          w_frame;
    t_bundle         w_bundle;
    logic            w_free;
    logic            w_fire;
    t_event          w_event;
    logic [5:0][7:0] w_data;

    assign w_data = {i_data_byte5, i_data_byte4, i_data_byte3,
                     i_data_byte2, i_data_byte1, i_data_byte0};

    // Advance a frame into decode only when the queue can take its events
    assign w_fire = w_frame_vld && w_free;

    cscd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_can_id    (i_can_id),
        .i_dlc       (i_dlc),
        .i_data      (w_data),
        .i_take      (w_fire),
        .o_frame_vld (w_frame_vld),
        .o_frame     (w_frame)
    );

    cscd_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (w_frame),
        .i_fire   (w_fire),
        .o_bundle (w_bundle)
    );

    cscd_out_queue u_oq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_bundle (w_bundle),
        .o_free   (w_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_event  (w_event),
        .o_last   (o_last_of_frame)
    );

    assign o_signal_kind  = w_event.kind;
    assign o_signal_value = w_event.value;

endmodule

`default_nettype wire

// ===== bench/tb_can_signal_decoder_change_detect_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_signal_decoder_change_detect_unit
// Self-checking bench for the dashboard CAN decoder with change detection.
// Frames are fed from a queue, and each accepted frame is decoded again by a
// behavioural copy of the signal store. The events it predicts are checked,
// in order and field by field, against the event beats the block returns.
// ----------------------------------------------------------------------------

module tb_can_signal_decoder_change_detect_unit;

    import cscd_pkg::*;

    // Cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // Settling time once the last expected event has arrived
    localparam int TAIL_CYCLES = 20;
    // Frames offered over the whole run
    localparam int NUM_FRAMES = 300;

    typedef struct packed {
        logic        drain;   // hold this frame back until all events are in
        logic [31:0] id;
        logic [3:0]  dlc;
        logic [47:0] data;    // byte k sits at [8*k +: 8]
    } t_stim_frame;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic        last;
    } t_exp_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_can_id = '0;
    logic [3:0]  i_dlc = '0;
    logic [7:0]  i_data_byte0 = '0;
    logic [7:0]  i_data_byte1 = '0;
    logic [7:0]  i_data_byte2 = '0;
    logic [7:0]  i_data_byte3 = '0;
    logic [7:0]  i_data_byte4 = '0;
    logic [7:0]  i_data_byte5 = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_signal_kind;
    logic [15:0] o_signal_value;
    logic        o_last_of_frame;

    can_signal_decoder_change_detect_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_can_id        (i_can_id),
        .i_dlc           (i_dlc),
        .i_data_byte0    (i_data_byte0),
        .i_data_byte1    (i_data_byte1),
        .i_data_byte2    (i_data_byte2),
        .i_data_byte3    (i_data_byte3),
        .i_data_byte4    (i_data_byte4),
        .i_data_byte5    (i_data_byte5),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_signal_kind   (o_signal_kind),
        .o_signal_value  (o_signal_value),
        .o_last_of_frame (o_last_of_frame)
    );

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    t_stim_frame pending_frames[$];     // frames still to be offered
    t_stim_frame cur_frame;             // frame currently on the input port
    t_exp_event  frame_changes[$];      // events of the frame being decoded
    t_exp_event  expected_events[$];    // events still owed by the block
    int     frames_taken = 0;
    int     quiet_cycles = 0;
    int     errors = 0;

    // Shadow copy of the dashboard signal store, starting at zero as after reset
    logic [15:0] dash_switch = '0;
    logic [7:0]  dash_gear = '0;
    logic [SPEED_W-1:0] dash_speed = '0;
    logic [15:0] dash_rpm = '0;
    logic [15:0] dash_warning = '0;
    logic        dash_abs = 1'b0;
    logic        dash_tcs = 1'b0;
    logic [7:0]  dash_temp = '0;
    logic [7:0]  dash_oil = '0;
    logic [7:0]  dash_fuel = '0;

    // No random idling on either side while this window of frames goes through
    wire steady = (frames_taken >= 120) && (frames_taken < 200);

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Shortest length code that lets a frame decode; unknown ids never do
    function automatic int min_len(input logic [31:0] id);
        case (id)
            ID_SWITCH:  return int'(DLC_SWITCH);
            ID_GEAR:    return int'(DLC_GEAR);
            ID_SPEED:   return int'(DLC_SPEED);
            ID_WARNING: return int'(DLC_WARNING);
            ID_VEHICLE: return int'(DLC_VEHICLE);
            ID_ENGINE:  return int'(DLC_ENGINE);
            default:    return 99;
        endcase
    endfunction

    // Record one event when the decoded value differs from the held one
    function automatic void note_change(input logic [3:0] kind,
                                        input logic [15:0] held,
                                        input logic [15:0] fresh);
        t_exp_event ev;
        if (held != fresh) begin
            ev.kind  = kind;
            ev.value = fresh;
            ev.last  = 1'b0;
            frame_changes.push_back(ev);
        end
    endfunction

    // Decode one accepted frame, update the shadow store and queue the
    // events it should raise, marking the final one of the frame
    function automatic void predict_events(input t_stim_frame f);
        logic [7:0]  b [0:5];
        logic [15:0] word;
        logic [15:0] speed_calc;
        t_exp_event  ev;
        for (int k = 0; k < 6; k++) begin
            b[k] = f.data[8*k +: 8];
        end
        frame_changes.delete();
        if (int'(f.dlc) >= min_len(f.id)) begin
            case (f.id)
                ID_SWITCH: begin
                    word = {b[1], b[0]};
                    note_change(KIND_SWITCH, dash_switch, word);
                    dash_switch = word;
                end
                ID_GEAR: begin
                    note_change(KIND_GEAR, {8'd0, dash_gear}, {8'd0, b[0]});
                    dash_gear = b[0];
                end
                ID_SPEED: begin
                    // Speed word is big-endian, in tenths
                    word = {b[0], b[1]};
                    speed_calc = word / 16'd10;
                    note_change(KIND_SPEED, {{(16-SPEED_W){1'b0}}, dash_speed},
                                speed_calc);
                    dash_speed = speed_calc[SPEED_W-1:0];
                    word = {b[2], b[3]};
                    note_change(KIND_RPM, dash_rpm, word);
                    dash_rpm = word;
                end
                ID_WARNING: begin
                    word = {b[1], b[0]};
                    note_change(KIND_WARNING, dash_warning, word);
                    dash_warning = word;
                end
                ID_VEHICLE: begin
                    // Gear is shared with the gear frame
                    note_change(KIND_GEAR, {8'd0, dash_gear}, {8'd0, b[4]});
                    dash_gear = b[4];
                    note_change(KIND_ABS, {15'd0, dash_abs}, {15'd0, b[5][0]});
                    dash_abs = b[5][0];
                    note_change(KIND_TCS, {15'd0, dash_tcs}, {15'd0, b[5][1]});
                    dash_tcs = b[5][1];
                end
                ID_ENGINE: begin
                    note_change(KIND_TEMP, {8'd0, dash_temp}, {8'd0, b[0]});
                    dash_temp = b[0];
                    note_change(KIND_OIL, {8'd0, dash_oil}, {8'd0, b[1]});
                    dash_oil = b[1];
                    note_change(KIND_FUEL, {8'd0, dash_fuel}, {8'd0, b[2]});
                    dash_fuel = b[2];
                end
                default: begin
                end
            endcase
        end
        for (int k = 0; k < frame_changes.size(); k++) begin
            ev = frame_changes[k];
            ev.last = (k == frame_changes.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_frame(input logic [31:0] id, input logic [3:0] dlc,
                                        input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4, input logic [7:0] b5,
                                        input logic drain);
        t_stim_frame f;
        f.drain = drain;
        f.id    = id;
        f.dlc   = dlc;
        f.data  = {b5, b4, b3, b2, b1, b0};
        pending_frames.push_back(f);
    endfunction

    // Bias towards the extremes so that values repeat and frames go quiet
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame driver: advance to the next frame once the current beat has
    // gone, idle now and then, and hold a marked frame back until every
    // outstanding event has drained
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_events(cur_frame);
                frames_taken <= frames_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_frames.size() == 0 ||
                    (pending_frames[0].drain && expected_events.size() != 0) ||
                    (!steady && $urandom_range(0, 99) < 6)) begin
                    i_valid <= 1'b0;
                end else begin
                    cur_frame = pending_frames.pop_front();
                    i_valid      <= 1'b1;
                    i_can_id     <= cur_frame.id;
                    i_dlc        <= cur_frame.dlc;
                    i_data_byte0 <= cur_frame.data[7:0];
                    i_data_byte1 <= cur_frame.data[15:8];
                    i_data_byte2 <= cur_frame.data[23:16];
                    i_data_byte3 <= cur_frame.data[31:24];
                    i_data_byte4 <= cur_frame.data[39:32];
                    i_data_byte5 <= cur_frame.data[47:40];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Event side: stall now and then, check every accepted beat against
    // the oldest expected event
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge i_clk) begin
        t_exp_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event: kind %0d value %0d last %0d",
                         $time, o_signal_kind, o_signal_value, o_last_of_frame);
                errors++;
            end else begin
                want = expected_events.pop_front();
                if (o_signal_kind !== want.kind) begin
                    $display("%0t: signal_kind mismatch: expected %0d, got %0d",
                             $time, want.kind, o_signal_kind);
                    errors++;
                end
                if (o_signal_value !== want.value) begin
                    $display("%0t: signal_value mismatch: expected %0d, got %0d",
                             $time, want.value, o_signal_value);
                    errors++;
                end
                if (o_last_of_frame !== want.last) begin
                    $display("%0t: last_of_frame mismatch: expected %0d, got %0d",
                             $time, want.last, o_last_of_frame);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < HANG_LIMIT) @(posedge i_clk);
        $display("[can_signal_decoder_change_detect_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          decoded;
        int          pick;
        logic [31:0] id;
        logic [3:0]  dlc;
        logic [47:0] data;

        // Directed frames: extremes, short codes, long codes, quiet frames
        queue_frame(32'h0, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_frame(ID_SWITCH, 4'd2, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_SWITCH, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_SWITCH, 4'd8, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        queue_frame(ID_GEAR, 4'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_GEAR, 4'd0, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_SPEED, 4'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_SPEED, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        // Length code above eight still decodes; 9 tenths rounds down to zero
        queue_frame(ID_SPEED, 4'd15, 8'h00, 8'h09, 8'h00, 8'h01, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_WARNING, 4'd2, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_WARNING, 4'd9, 8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_VEHICLE, 4'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h03, 1'b0);
        queue_frame(ID_VEHICLE, 4'd5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 1'b0);
        queue_frame(ID_VEHICLE, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'hFE, 1'b0);
        // Gear frame repeating the gear set by the vehicle frame stays quiet
        queue_frame(ID_GEAR, 4'd1, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_ENGINE, 4'd3, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_ENGINE, 4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_ENGINE, 4'd3, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(32'hFFFF_FFFF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // Flag bits in the upper word defeat the exact match
        queue_frame(ID_SWITCH | 32'h8000_0000, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 1'b0);
        queue_frame(ID_SWITCH, 4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_ENGINE, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_frame(ID_VEHICLE, 4'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

        // Random frames: mostly decodable, some noise and short codes
        decoded = 0;
        data = '0;
        while (pending_frames.size() < NUM_FRAMES) begin
            case ($urandom_range(0, 5))
                0:       id = ID_SWITCH;
                1:       id = ID_GEAR;
                2:       id = ID_SPEED;
                3:       id = ID_WARNING;
                4:       id = ID_VEHICLE;
                default: id = ID_ENGINE;
            endcase
            dlc = 4'($urandom_range(min_len(id), 15));
            // Reuse the previous payload now and then to get quiet frames
            if ($urandom_range(0, 4) != 0) begin
                data = {rand_byte(), rand_byte(), rand_byte(),
                        rand_byte(), rand_byte(), rand_byte()};
            end
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                id  = $urandom;
                dlc = 4'($urandom);
            end else if (pick == 2) begin
                id = id | (32'd1 << $urandom_range(11, 31));
            end else if (pick == 3) begin
                dlc = 4'($urandom_range(0, min_len(id) - 1));
            end
            queue_frame(id, dlc, data[7:0], data[15:8], data[23:16], data[31:24],
                        data[39:32], data[47:40], (decoded == 0 || decoded == 150));
            if (int'(dlc) >= min_len(id)) begin
                decoded++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_frames.size() != 0 || i_valid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray event surface before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_events.size() == 0) begin
            $display("[can_signal_decoder_change_detect_unit] OK");
        end else begin
            $display("[can_signal_decoder_change_detect_unit] ERROR");
        end
        $finish;
    end

endmodule
